@@ design/mabu_pkg.sv @@
// Package for the minicomputer ALU and branch unit.
// Holds the decoded-instruction and result types, opcode names and status codes.
// No dependencies.
`default_nettype none

package mabu_pkg;

   typedef enum logic [3:0] {
      K_DOUBLE,
      K_MUL,
      K_DIV,
      K_ASH,
      K_ASHC,
      K_XOR,
      K_SOB,
      K_SWAB,
      K_BRANCH,
      K_SINGLE,
      K_NOMATCH
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_RUN,
      BK_DIV_DONE
   } back_state_type;

   // Double-operand operations.
   localparam logic [2:0] DOP_MOV = 3'd1;
   localparam logic [2:0] DOP_CMP = 3'd2;
   localparam logic [2:0] DOP_BIT = 3'd3;
   localparam logic [2:0] DOP_BIC = 3'd4;
   localparam logic [2:0] DOP_BIS = 3'd5;
   localparam logic [2:0] DOP_ADD = 3'd6;
   localparam logic [2:0] DOP_SUB = 3'd7;

   // Register-group operations (instruction bits 11:9 of the 07xxxx group).
   localparam logic [2:0] XOP_MUL  = 3'd0;
   localparam logic [2:0] XOP_DIV  = 3'd1;
   localparam logic [2:0] XOP_ASH  = 3'd2;
   localparam logic [2:0] XOP_ASHC = 3'd3;
   localparam logic [2:0] XOP_XOR  = 3'd4;
   localparam logic [2:0] XOP_SOB  = 3'd7;

   // Single-operand operations (instruction bits 11:6).
   localparam logic [5:0] SOP_CLR = 6'h28;
   localparam logic [5:0] SOP_COM = 6'h29;
   localparam logic [5:0] SOP_INC = 6'h2a;
   localparam logic [5:0] SOP_DEC = 6'h2b;
   localparam logic [5:0] SOP_NEG = 6'h2c;
   localparam logic [5:0] SOP_ADC = 6'h2d;
   localparam logic [5:0] SOP_SBC = 6'h2e;
   localparam logic [5:0] SOP_TST = 6'h2f;
   localparam logic [5:0] SOP_ROR = 6'h30;
   localparam logic [5:0] SOP_ROL = 6'h31;
   localparam logic [5:0] SOP_ASR = 6'h32;
   localparam logic [5:0] SOP_ASL = 6'h33;
   localparam logic [5:0] SOP_SXT = 6'h37;

   // Branch conditions: {instruction bit 15, bits 10:8}.
   localparam logic [3:0] BR_BR   = 4'd1;
   localparam logic [3:0] BR_BNE  = 4'd2;
   localparam logic [3:0] BR_BEQ  = 4'd3;
   localparam logic [3:0] BR_BGE  = 4'd4;
   localparam logic [3:0] BR_BLT  = 4'd5;
   localparam logic [3:0] BR_BGT  = 4'd6;
   localparam logic [3:0] BR_BLE  = 4'd7;
   localparam logic [3:0] BR_BPL  = 4'd8;
   localparam logic [3:0] BR_BMI  = 4'd9;
   localparam logic [3:0] BR_BHI  = 4'd10;
   localparam logic [3:0] BR_BLOS = 4'd11;
   localparam logic [3:0] BR_BVC  = 4'd12;
   localparam logic [3:0] BR_BVS  = 4'd13;
   localparam logic [3:0] BR_BCC  = 4'd14;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOMATCH = 2'd1;
   localparam logic [1:0] ST_FAULT   = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic        byte_op;
      logic [5:0]  sel;
      logic [15:0] ins;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] ap;
      logic [15:0] pc;
   } entry_type;

   typedef struct packed {
      logic [15:0] result_word;
      logic [15:0] result_pair_word;
      logic        write_result;
      logic        write_pair;
      logic [15:0] next_pc;
      logic        n;
      logic        z;
      logic        v;
      logic        c;
      logic [1:0]  status;
   } res_type;

endpackage

`default_nettype wire

@@ design/mabu_front.sv @@
// Front end of the ALU and branch unit: accepts instruction transactions and
// classifies them by the masked opcode table. Depends on mabu_pkg.
`default_nettype none

module mabu_front (
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [79:0]         req_tdata,
   input  wire logic                q_full,
   output logic                     q_push,
   output mabu_pkg::entry_type      q_entry
);
   import mabu_pkg::*;

   logic [15:0] ins;
   logic [3:0]  top;
   logic [5:0]  code;

   assign ins  = req_tdata[15:0];
   assign top  = ins[15:12];
   assign code = ins[11:6];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_entry         = '0;
      q_entry.ins     = ins;
      q_entry.a       = req_tdata[31:16];
      q_entry.b       = req_tdata[47:32];
      q_entry.ap      = req_tdata[63:48];
      q_entry.pc      = req_tdata[79:64];
      q_entry.kind    = K_NOMATCH;
      q_entry.byte_op = 1'b0;
      q_entry.sel     = 6'd0;
      if (top inside {[4'd1:4'd6], [4'd9:4'd14]}) begin
         q_entry.kind    = K_DOUBLE;
         q_entry.byte_op = top[3] && (top != 4'd14);
         q_entry.sel     = {3'd0, (top == 4'd14) ? DOP_SUB : top[2:0]};
      end else if (top == 4'd7) begin
         case (ins[11:9])
            XOP_MUL:  q_entry.kind = K_MUL;
            XOP_DIV:  q_entry.kind = K_DIV;
            XOP_ASH:  q_entry.kind = K_ASH;
            XOP_ASHC: q_entry.kind = K_ASHC;
            XOP_XOR:  q_entry.kind = K_XOR;
            XOP_SOB:  q_entry.kind = K_SOB;
            default:  q_entry.kind = K_NOMATCH;
         endcase
      end else if (ins[15:6] == 10'b0000000011) begin
         q_entry.kind = K_SWAB;
      end else if ((ins[14:11] == 4'd0) && (ins[15] || (ins[10:8] != 3'd0))) begin
         q_entry.kind = K_BRANCH;
         q_entry.sel  = {2'd0, ins[15], ins[10:8]};
      end else if (ins[14:12] == 3'd0) begin
         // Single-operand group; the sign-extend exists in word form only.
         if ((code inside {[SOP_CLR:SOP_ASL]}) || ((code == SOP_SXT) && !ins[15])) begin
            q_entry.kind    = K_SINGLE;
            q_entry.byte_op = ins[15];
            q_entry.sel     = code;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/mabu_queue.sv @@
// Short FIFO of decoded instructions between the front and back ends.
// Depends on mabu_pkg.
`default_nettype none

module mabu_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire mabu_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     valid,
   output mabu_pkg::entry_type      head
);
   import mabu_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

   entry_type     mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == FULLCNT);
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ design/mabu_back.sv @@
// Back end of the ALU and branch unit: executes decoded instructions, keeps
// the condition codes, runs the bit-serial divider and holds the result
// register. Depends on mabu_pkg.
`default_nettype none

module mabu_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire mabu_pkg::entry_type q_head,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output mabu_pkg::res_type        rsp_res
);
   import mabu_pkg::*;

   back_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   res_type        out_ff, out_in;
   logic [3:0]     flags_ff, flags_in;
   entry_type      cur_ff;
   logic [15:0]    dv_rem_ff, dv_rem_in;
   logic [31:0]    dv_quo_ff, dv_quo_in;
   logic [15:0]    dv_dvs_ff;
   logic [4:0]     dv_cnt_ff;

   logic           out_free, start_div, div_step, load_out, sel_div;
   logic           is_div_start;
   res_type        exe, dres, chosen;
   entry_type      e;
   logic           fn, fz, fv, fc;

   // Execute datapath signals.
   logic [15:0]        m, sb, s, d, r, x;
   logic [16:0]        sum;
   logic signed [31:0] prod;
   logic               in_range, dbl, nc;
   logic [5:0]         cnt6, k6;
   logic [4:0]         km1;
   logic [31:0]        word32, wm32, r32;
   logic [63:0]        shl64, x64, shm;
   logic               tk, nv;
   logic [15:0]        sobres;

   // Divider signals.
   logic [16:0]        trial;
   logic               ge;
   logic [31:0]        dvd_abs;
   logic               dneg, dovf;

   assign e            = q_head;
   assign fn           = flags_ff[3];
   assign fz           = flags_ff[2];
   assign fv           = flags_ff[1];
   assign fc           = flags_ff[0];
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign is_div_start = (e.kind == K_DIV) && (e.b != 16'd0);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_res      = out_ff;

   assign prod = $signed(e.a) * $signed(e.b);

   // Instruction execute for everything but a nonzero divide.
   always_comb begin
      exe         = '0;
      exe.next_pc = e.pc;
      exe.n       = fn;
      exe.z       = fz;
      exe.v       = fv;
      exe.c       = fc;
      exe.status  = ST_DONE;
      m      = e.byte_op ? 16'h00ff : 16'hffff;
      sb     = e.byte_op ? 16'h0080 : 16'h8000;
      s      = e.a & m;
      d      = e.b & m;
      x      = e.a & m;
      r      = '0;
      sum    = {1'b0, s} + {1'b0, d};
      nc     = 1'b0;
      cnt6   = e.b[5:0];
      k6     = 6'd0 - cnt6;
      km1    = 5'(k6 - 6'd1);
      in_range = (e.b[15:5] == '0) || (e.b[15:5] == '1);
      dbl    = (e.kind == K_ASHC);
      word32 = dbl ? {e.a, e.ap} : {16'd0, e.a};
      wm32   = dbl ? 32'hffffffff : 32'h0000ffff;
      shl64  = {32'd0, word32} << cnt6[4:0];
      x64    = dbl ? {{32{e.a[15]}}, e.a, e.ap} : {{48{e.a[15]}}, e.a};
      shm    = x64 >> km1;
      r32    = '0;
      nv     = fn ^ fv;
      tk     = 1'b0;
      sobres = e.a - 16'd1;
      case (e.kind)
         K_DOUBLE: begin
            exe.v = 1'b0;
            case (e.sel[2:0])
               DOP_MOV: begin
                  r = s;
                  exe.write_result = 1'b1;
               end
               DOP_CMP: begin
                  r = (s - d) & m;
                  exe.c = s < d;
                  exe.v = ((s ^ d) & sb) != 0 && ((d ^ r) & sb) == 0;
               end
               DOP_BIT: r = s & d;
               DOP_BIC: begin
                  r = ~s & d & m;
                  exe.write_result = 1'b1;
               end
               DOP_BIS: begin
                  r = s | d;
                  exe.write_result = 1'b1;
               end
               DOP_ADD: begin
                  r = sum[15:0] & m;
                  exe.c = sum > {1'b0, m};
                  exe.v = ((s ^ d) & sb) == 0 && ((s ^ r) & sb) != 0;
                  exe.write_result = 1'b1;
               end
               default: begin
                  r = (d - s) & m;
                  exe.c = d < s;
                  exe.v = ((s ^ d) & sb) != 0 && ((s ^ r) & sb) == 0;
                  exe.write_result = 1'b1;
               end
            endcase
            exe.n = (r & sb) != 0;
            exe.z = (r == 16'd0);
            if (exe.write_result) begin
               exe.result_word = e.byte_op ? {e.b[15:8], r[7:0]} : r;
            end
         end
         K_MUL: begin
            if (e.ins[6]) begin
               exe.result_word  = prod[15:0];
               exe.write_result = 1'b1;
            end else begin
               exe.result_word      = prod[31:16];
               exe.result_pair_word = prod[15:0];
               exe.write_result     = 1'b1;
               exe.write_pair       = 1'b1;
            end
            exe.n = prod[31];
            exe.z = (prod == 32'sd0);
            exe.v = 1'b0;
            exe.c = !((prod[31:15] == '0) || (prod[31:15] == '1));
         end
         K_DIV: begin
            // Only a zero divisor gets here; the rest goes through the divider.
            exe.v      = 1'b1;
            exe.c      = 1'b1;
            exe.status = ST_FAULT;
         end
         K_ASH, K_ASHC: begin
            if (!in_range) begin
               exe.status = ST_FAULT;
            end else begin
               if (cnt6 == 6'd0) begin
                  r32   = word32;
                  exe.c = 1'b0;
                  exe.v = 1'b0;
               end else if (!cnt6[5]) begin
                  r32   = shl64[31:0] & wm32;
                  exe.c = dbl ? shl64[32] : shl64[16];
                  exe.v = dbl ? (r32[31] ^ word32[31]) : (r32[15] ^ word32[15]);
               end else begin
                  r32   = shm[32:1] & wm32;
                  exe.c = shm[0];
                  exe.v = 1'b0;
               end
               exe.n = dbl ? r32[31] : r32[15];
               exe.z = (r32 == 32'd0);
               exe.write_result = 1'b1;
               if (dbl) begin
                  exe.result_word      = r32[31:16];
                  exe.result_pair_word = r32[15:0];
                  exe.write_pair       = 1'b1;
               end else begin
                  exe.result_word = r32[15:0];
               end
            end
         end
         K_XOR: begin
            exe.result_word  = e.a ^ e.b;
            exe.write_result = 1'b1;
            exe.n = exe.result_word[15];
            exe.z = (exe.result_word == 16'd0);
            exe.v = 1'b0;
         end
         K_SOB: begin
            exe.result_word  = sobres;
            exe.write_result = 1'b1;
            if (sobres != 16'd0) begin
               exe.next_pc = e.pc - {9'd0, e.ins[5:0], 1'b0};
            end
         end
         K_SWAB: begin
            exe.result_word  = {e.a[7:0], e.a[15:8]};
            exe.write_result = 1'b1;
            exe.n = e.a[15];
            exe.z = (e.a[15:8] == 8'd0);
            exe.v = 1'b0;
            exe.c = 1'b0;
         end
         K_BRANCH: begin
            case (e.sel[3:0])
               BR_BR:   tk = 1'b1;
               BR_BNE:  tk = !fz;
               BR_BEQ:  tk = fz;
               BR_BGE:  tk = !nv;
               BR_BLT:  tk = nv;
               BR_BGT:  tk = !(fz || nv);
               BR_BLE:  tk = fz || nv;
               BR_BPL:  tk = !fn;
               BR_BMI:  tk = fn;
               BR_BHI:  tk = !(fc || fz);
               BR_BLOS: tk = fc || fz;
               BR_BVC:  tk = !fv;
               BR_BVS:  tk = fv;
               BR_BCC:  tk = !fc;
               default: tk = fc;
            endcase
            if (tk) begin
               exe.next_pc = e.pc + {{7{e.ins[7]}}, e.ins[7:0], 1'b0};
            end
         end
         K_SINGLE: begin
            exe.write_result = 1'b1;
            case (e.sel)
               SOP_CLR: begin
                  r = 16'd0;
                  exe.v = 1'b0;
                  exe.c = 1'b0;
               end
               SOP_COM: begin
                  r = ~x & m;
                  exe.v = 1'b0;
                  exe.c = 1'b1;
               end
               SOP_INC: begin
                  r = (x + 16'd1) & m;
                  exe.v = (x == sb - 16'd1);
               end
               SOP_DEC: begin
                  r = (x - 16'd1) & m;
                  exe.v = (x == sb);
               end
               SOP_NEG: begin
                  r = (16'd0 - x) & m;
                  exe.v = (r == sb);
                  exe.c = (r != 16'd0);
               end
               SOP_ADC: begin
                  r = (x + {15'd0, fc}) & m;
                  exe.v = (x == sb - 16'd1) && fc;
                  exe.c = (x == m) && fc;
               end
               SOP_SBC: begin
                  r = (x - {15'd0, fc}) & m;
                  exe.v = (x == sb);
                  exe.c = (x == 16'd0) && fc;
               end
               SOP_TST: begin
                  r = x;
                  exe.v = 1'b0;
                  exe.c = 1'b0;
                  exe.write_result = 1'b0;
               end
               SOP_ROR: begin
                  nc = x[0];
                  r = (x >> 1) | (fc ? sb : 16'd0);
               end
               SOP_ROL: begin
                  nc = (x & sb) != 0;
                  r = ((x << 1) & m) | {15'd0, fc};
               end
               SOP_ASR: begin
                  nc = x[0];
                  r = (x >> 1) | (x & sb);
               end
               SOP_ASL: begin
                  nc = (x & sb) != 0;
                  r = (x << 1) & m;
               end
               default: begin
                  // Sign extend: Z is set when the old N is clear, N is left alone.
                  r = fn ? 16'hffff : 16'd0;
                  exe.z = !fn;
                  exe.v = 1'b0;
               end
            endcase
            if (e.sel != SOP_SXT) begin
               exe.n = (r & sb) != 0;
               exe.z = (r == 16'd0);
            end
            if (e.sel inside {[SOP_ROR:SOP_ASL]}) begin
               exe.c = nc;
               exe.v = exe.n ^ nc;
            end
            if (exe.write_result) begin
               exe.result_word = e.byte_op ? {e.a[15:8], r[7:0]} : r;
            end
         end
         default: exe.status = ST_NOMATCH;
      endcase
   end

   // Divider: restoring, one quotient bit per cycle on the magnitudes.
   assign trial   = {dv_rem_ff, dv_quo_ff[31]};
   assign ge      = trial >= {1'b0, dv_dvs_ff};
   assign dvd_abs = e.a[15] ? (32'd0 - {e.a, e.ap}) : {e.a, e.ap};
   assign dneg    = cur_ff.a[15] ^ cur_ff.b[15];
   assign dovf    = dneg ? (dv_quo_ff > 32'd32768) : (dv_quo_ff > 32'd32767);

   always_comb begin
      dv_rem_in = ge ? 16'(trial - {1'b0, dv_dvs_ff}) : trial[15:0];
      dv_quo_in = {dv_quo_ff[30:0], ge};
   end

   always_comb begin
      dres         = '0;
      dres.next_pc = cur_ff.pc;
      dres.n       = fn;
      dres.z       = fz;
      dres.status  = ST_DONE;
      if (dovf) begin
         dres.v      = 1'b1;
         dres.c      = 1'b0;
         dres.status = ST_FAULT;
      end else begin
         dres.result_word      = dneg ? (16'd0 - dv_quo_ff[15:0]) : dv_quo_ff[15:0];
         dres.result_pair_word = cur_ff.a[15] ? (16'd0 - dv_rem_ff) : dv_rem_ff;
         dres.write_result     = 1'b1;
         dres.write_pair       = 1'b1;
         dres.n = dneg && (dv_quo_ff != 32'd0);
         dres.z = (dv_quo_ff == 32'd0);
         dres.v = 1'b0;
         dres.c = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && is_div_start) begin
               state_in = BK_DIV_RUN;
            end
         end
         BK_DIV_RUN: begin
            if (dv_cnt_ff == '1) begin
               state_in = BK_DIV_DONE;
            end
         end
         BK_DIV_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      q_pop     = 1'b0;
      start_div = 1'b0;
      div_step  = 1'b0;
      load_out  = 1'b0;
      sel_div   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && is_div_start) begin
               q_pop     = 1'b1;
               start_div = 1'b1;
            end else if (q_valid && out_free) begin
               q_pop    = 1'b1;
               load_out = 1'b1;
            end
         end
         BK_DIV_RUN: div_step = 1'b1;
         BK_DIV_DONE: begin
            load_out = out_free;
            sel_div  = 1'b1;
         end
         default: ;
      endcase
   end

   assign chosen   = sel_div ? dres : exe;
   assign out_in   = chosen;
   assign flags_in = {chosen.n, chosen.z, chosen.v, chosen.c};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= 4'd0;
         dv_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            flags_ff <= flags_in;
         end
         if (start_div) begin
            dv_cnt_ff <= '0;
         end else if (div_step) begin
            dv_cnt_ff <= dv_cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= out_in;
      end
      if (start_div) begin
         cur_ff    <= e;
         dv_rem_ff <= 16'd0;
         dv_quo_ff <= dvd_abs;
         dv_dvs_ff <= e.b[15] ? (16'd0 - e.b) : e.b;
      end else if (div_step) begin
         dv_rem_ff <= dv_rem_in;
         dv_quo_ff <= dv_quo_in;
      end
   end

endmodule

`default_nettype wire

@@ design/minicomputer_alu_branch_unit.sv @@
// Top level of the 16-bit minicomputer ALU and branch unit with N, Z, V, C.
// Instantiates mabu_front, mabu_queue and mabu_back; uses mabu_pkg.
//
// One instruction transaction in gives one result transaction out. The front end
// decodes the instruction into the queue in the cycle it is accepted; the back
// end executes the queue head into the result register when that register is
// free, so one instruction other than a divide by a nonzero value can complete
// per cycle while no divide runs and the response side takes every result. A
// divide runs the bit-serial restoring divider, one quotient bit per cycle over
// the 32-bit dividend; the queue keeps accepting while it runs, until full.
// The condition codes are cleared by reset.
`default_nettype none

module minicomputer_alu_branch_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // instruction, operand_a, operand_b, operand_a_pair, program_counter
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_word, result_pair_word, write_result, write_pair, next_pc,
   // flag_negative, flag_zero, flag_overflow, flag_carry, status
   output logic [55:0]      rsp_tdata
);
   import mabu_pkg::*;

   entry_type push_entry, head;
   logic      push, full, pop, valid;
   res_type   res;

   mabu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   mabu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .valid      (valid),
      .head       (head)
   );

   mabu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (valid),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (res)
   );

   assign rsp_tdata = {res.status, res.c, res.v, res.z, res.n, res.next_pc,
                       res.write_pair, res.write_result,
                       res.result_pair_word, res.result_word};

endmodule

`default_nettype wire

@@ dv/mabu_checker.sv @@
// Scoreboard for the minicomputer ALU and branch unit: predicts every response
// from the accepted requests and compares it field by field. Uses no package.
`timescale 1ns / 100ps

module mabu_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,
   output int               mismatch_count,
   output int               pending_count
);

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOMATCH = 2'd1;
   localparam logic [1:0] ST_FAULT   = 2'd2;

   localparam logic [2:0] OP_MOV = 3'd1, OP_CMP = 3'd2, OP_BIT = 3'd3, OP_BIC = 3'd4;
   localparam logic [2:0] OP_BIS = 3'd5, OP_ADD = 3'd6;
   localparam logic [2:0] GRP_MUL = 3'd0, GRP_DIV = 3'd1, GRP_ASH = 3'd2, GRP_ASHC = 3'd3;
   localparam logic [2:0] GRP_XOR = 3'd4, GRP_SOB = 3'd7;
   localparam logic [5:0] UN_CLR = 6'h28, UN_COM = 6'h29, UN_INC = 6'h2a, UN_DEC = 6'h2b;
   localparam logic [5:0] UN_NEG = 6'h2c, UN_ADC = 6'h2d, UN_SBC = 6'h2e, UN_TST = 6'h2f;
   localparam logic [5:0] UN_ROR = 6'h30, UN_ROL = 6'h31, UN_ASR = 6'h32, UN_ASL = 6'h33;
   localparam logic [3:0] CND_BR = 4'd1, CND_BNE = 4'd2, CND_BEQ = 4'd3, CND_BGE = 4'd4;
   localparam logic [3:0] CND_BLT = 4'd5, CND_BGT = 4'd6, CND_BLE = 4'd7, CND_BPL = 4'd8;
   localparam logic [3:0] CND_BMI = 4'd9, CND_BHI = 4'd10, CND_BLOS = 4'd11;
   localparam logic [3:0] CND_BVC = 4'd12, CND_BVS = 4'd13, CND_BCC = 4'd14;

   typedef struct {
      logic [15:0] word;
      logic [15:0] pair_word;
      logic        wr;
      logic        wp;
      logic [15:0] npc;
      logic        n, z, v, c;
      logic [1:0]  status;
   } alu_outcome_type;

   logic            flag_n, flag_z, flag_v, flag_c;
   alu_outcome_type expected_outcomes[$];
   int              shown;

   function automatic alu_outcome_type unpack_outcome(input logic [55:0] d);
      alu_outcome_type o;
      o.word = d[15:0];   o.pair_word = d[31:16];
      o.wr = d[32];       o.wp = d[33];
      o.npc = d[49:34];
      o.n = d[50]; o.z = d[51]; o.v = d[52]; o.c = d[53];
      o.status = d[55:54];
      return o;
   endfunction

   // Executes one instruction against the tracked condition codes.
   function automatic alu_outcome_type execute_instruction(input logic [79:0] rq);
      alu_outcome_type o;
      logic [15:0] ins, a, b, ap, pc;
      logic [31:0] res, pair, m, sb, s, d, r, x, code, off;
      logic [63:0] word, wm, sgn, w, r64, x64;
      logic [3:0]  top, idx;
      logic [2:0]  op, sub;
      logic        n, z, v, c, wr, wp, bytemode, dbl, nc, setnz, t, nv;
      logic [1:0]  st;
      int          p, cnt, k;
      longint      dvs, dvd, q, rm;
      ins = rq[15:0]; a = rq[31:16]; b = rq[47:32]; ap = rq[63:48]; pc = rq[79:64];
      n = flag_n; z = flag_z; v = flag_v; c = flag_c;
      res = 0; pair = 0; wr = 0; wp = 0; st = ST_DONE;
      o.npc = pc;
      top = ins[15:12];
      if ((top >= 1 && top <= 6) || (top >= 9 && top <= 14)) begin
         bytemode = top >= 8 && top != 14;
         op = (top == 14) ? 3'd7 : top[2:0];
         m = bytemode ? 32'hff : 32'hffff;
         sb = bytemode ? 32'h80 : 32'h8000;
         s = a & m; d = b & m; r = 0;
         v = 0;
         case (op)
            OP_MOV: begin r = s; wr = 1; end
            OP_CMP: begin
               r = (s - d) & m; c = s < d;
               v = ((s ^ d) & sb) != 0 && ((d ^ r) & sb) == 0;
            end
            OP_BIT: r = s & d;
            OP_BIC: begin r = ~s & d & m; wr = 1; end
            OP_BIS: begin r = s | d; wr = 1; end
            OP_ADD: begin
               r = (s + d) & m; c = (s + d) > m;
               v = ((s ^ d) & sb) == 0 && ((s ^ r) & sb) != 0; wr = 1;
            end
            default: begin
               r = (d - s) & m; c = d < s;
               v = ((s ^ d) & sb) != 0 && ((s ^ r) & sb) == 0; wr = 1;
            end
         endcase
         n = (r & sb) != 0; z = r == 0;
         if (wr) res = bytemode ? ((b & 32'hff00) | r) : r;
      end else if (top == 7) begin
         sub = ins[11:9];
         if (sub == GRP_MUL) begin
            p = $signed(a) * $signed(b);
            if (ins[6]) begin res = p & 32'hffff; wr = 1; end
            else begin
               res = p >>> 16; res = res & 32'hffff; pair = p & 32'hffff; wr = 1; wp = 1;
            end
            n = p < 0; z = p == 0; v = 0; c = p < -32768 || p > 32767;
         end else if (sub == GRP_DIV) begin
            dvs = $signed(b);
            dvd = $signed({a, ap});
            if (dvs == 0) begin v = 1; c = 1; st = ST_FAULT; end
            else begin
               q = dvd / dvs; rm = dvd % dvs;
               if (q < -32768 || q > 32767) begin v = 1; c = 0; st = ST_FAULT; end
               else begin
                  res = 32'(q & 32'hffff); pair = 32'(rm & 32'hffff); wr = 1; wp = 1;
                  n = q < 0; z = q == 0; v = 0; c = 0;
               end
            end
         end else if (sub == GRP_ASH || sub == GRP_ASHC) begin
            cnt = $signed(b);
            dbl = sub == GRP_ASHC;
            word = dbl ? {32'd0, a, ap} : {48'd0, a};
            wm = dbl ? 64'hffffffff : 64'hffff;
            sgn = dbl ? 64'h80000000 : 64'h8000;
            r64 = 0;
            if (cnt < -32 || cnt > 31) st = ST_FAULT;
            else begin
               if (cnt == 0) begin r64 = word; c = 0; v = 0; end
               else if (cnt > 0) begin
                  w = word << cnt;
                  r64 = w & wm;
                  c = dbl ? w[32] : w[16];
                  v = ((r64 ^ word) & sgn) != 0;
               end else begin
                  k = -cnt;
                  x64 = word | (((word & sgn) != 0) ? ~wm : 64'd0);
                  r64 = (x64 >> k) & wm;
                  c = x64[k-1];
                  v = 0;
               end
               n = (r64 & sgn) != 0; z = r64 == 0;
               if (dbl) begin res = r64[31:16]; pair = r64[15:0]; wr = 1; wp = 1; end
               else begin res = r64[15:0]; wr = 1; end
            end
         end else if (sub == GRP_XOR) begin
            res = a ^ b; wr = 1;
            n = res[15]; z = res == 0; v = 0;
         end else if (sub == GRP_SOB) begin
            res = (a - 32'd1) & 32'hffff; wr = 1;
            if (res != 0) o.npc = pc - 16'(2 * ins[5:0]);
         end else st = ST_NOMATCH;
      end else if ((ins & 16'hffc0) == 16'h00c0) begin
         res = {a[7:0], a[15:8]}; wr = 1;
         n = res[7]; z = res[7:0] == 0; v = 0; c = 0;
      end else if ((ins & 16'h7800) == 0 && (ins[15] || ins[10:8] != 0)) begin
         idx = {ins[15], ins[10:8]};
         nv = n != v;
         case (idx)
            CND_BR:   t = 1;
            CND_BNE:  t = !z;
            CND_BEQ:  t = z;
            CND_BGE:  t = !nv;
            CND_BLT:  t = nv;
            CND_BGT:  t = !(z || nv);
            CND_BLE:  t = z || nv;
            CND_BPL:  t = !n;
            CND_BMI:  t = n;
            CND_BHI:  t = !(c || z);
            CND_BLOS: t = c || z;
            CND_BVC:  t = !v;
            CND_BVS:  t = v;
            CND_BCC:  t = !c;
            default:  t = c;
         endcase
         off = {{24{ins[7]}}, ins[7:0]};
         if (t) o.npc = pc + 16'(2 * off);
      end else begin
         code = (ins & 16'h7fff) >> 6;
         bytemode = ins[15];
         m = bytemode ? 32'hff : 32'hffff;
         sb = bytemode ? 32'h80 : 32'h8000;
         x = a & m; r = 0;
         if ((ins & 16'h7000) != 0 || code < 32'h28 || code > 32'h37 ||
             (code >= 32'h34 && code <= 32'h36) || (code == 32'h37 && bytemode)) begin
            st = ST_NOMATCH;
         end else begin
            setnz = 1; wr = 1;
            case (code[5:0])
               UN_CLR: begin r = 0; v = 0; c = 0; end
               UN_COM: begin r = ~x & m; v = 0; c = 1; end
               UN_INC: begin r = (x + 1) & m; v = x == sb - 1; end
               UN_DEC: begin r = (x - 1) & m; v = x == sb; end
               UN_NEG: begin r = (0 - x) & m; v = r == sb; c = r != 0; end
               UN_ADC: begin
                  r = (x + c) & m; v = (x == sb - 1) && c; c = (x == m) && c;
               end
               UN_SBC: begin r = (x - c) & m; v = x == sb; c = (x == 0) && c; end
               UN_TST: begin r = x; v = 0; c = 0; wr = 0; end
               UN_ROR: begin nc = x[0]; r = (x >> 1) | (c ? sb : 0); c = nc; end
               UN_ROL: begin nc = (x & sb) != 0; r = ((x << 1) & m) | c; c = nc; end
               UN_ASR: begin nc = x[0]; r = (x >> 1) | (x & sb); c = nc; end
               UN_ASL: begin nc = (x & sb) != 0; r = (x << 1) & m; c = nc; end
               default: begin r = n ? 32'hffff : 0; z = !n; v = 0; setnz = 0; end
            endcase
            if (setnz) begin n = (r & sb) != 0; z = r == 0; end
            if (code >= 32'h30 && code <= 32'h33) v = n != c;
            if (wr) res = bytemode ? ((a & 32'hff00) | r) : r;
         end
      end
      flag_n = n; flag_z = z; flag_v = v; flag_c = c;
      o.word = wr ? res[15:0] : 16'd0;
      o.pair_word = wp ? pair[15:0] : 16'd0;
      o.wr = wr; o.wp = wp;
      o.n = n; o.z = z; o.v = v; o.c = c;
      o.status = st;
      return o;
   endfunction

   always @(posedge clock) begin
      alu_outcome_type e, g;
      string bad;
      if (reset) begin
         flag_n = 0; flag_z = 0; flag_v = 0; flag_c = 0;
         mismatch_count = 0;
         shown = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(execute_instruction(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            g = unpack_outcome(rsp_tdata);
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (shown < 10) begin
                  shown++;
                  $display("Unexpected response transaction %h", rsp_tdata);
               end
            end else begin
               e = expected_outcomes.pop_front();
               bad = "";
               if (g.word != e.word) bad = {bad, " result_word"};
               if (g.pair_word != e.pair_word) bad = {bad, " result_pair_word"};
               if (g.wr != e.wr) bad = {bad, " write_result"};
               if (g.wp != e.wp) bad = {bad, " write_pair"};
               if (g.npc != e.npc) bad = {bad, " next_pc"};
               if (g.n != e.n) bad = {bad, " flag_negative"};
               if (g.z != e.z) bad = {bad, " flag_zero"};
               if (g.v != e.v) bad = {bad, " flag_overflow"};
               if (g.c != e.c) bad = {bad, " flag_carry"};
               if (g.status != e.status) bad = {bad, " status"};
               if (bad != "") begin
                  mismatch_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("Mismatch in%s:", bad);
                     $display("   expected w=%h p=%h we=%b pe=%b pc=%h nzvc=%b%b%b%b st=%0d",
                              e.word, e.pair_word, e.wr, e.wp, e.npc,
                              e.n, e.z, e.v, e.c, e.status);
                     $display("   actual w=%h p=%h we=%b pe=%b pc=%h nzvc=%b%b%b%b st=%0d",
                              g.word, g.pair_word, g.wr, g.wp, g.npc,
                              g.n, g.z, g.v, g.c, g.status);
                  end
               end
            end
         end
      end
      pending_count = expected_outcomes.size();
   end

endmodule

@@ dv/tb_minicomputer_alu_branch_unit.sv @@
// Top of the testbench for minicomputer_alu_branch_unit: drives instruction
// transactions, throttles the response side and reports the verdict.
// Depends on the block and on mabu_checker.
`timescale 1ns / 100ps

module tb_minicomputer_alu_branch_unit;

   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   int          mismatch_count;
   int          pending_count;
   int          cycles;
   logic        no_idle;

   minicomputer_alu_branch_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   mabu_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // Operand values weighted toward the edges of the range.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         4: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic issue_instruction(input logic [15:0] ins, a, b, ap, pc);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {pc, ap, b, a, ins};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic issue_random();
      logic [15:0] ins, a, b, ap;
      logic [2:0]  grp;
      a = pick_word(); b = pick_word(); ap = pick_word();
      case ($urandom_range(0, 9))
         0, 1: begin
            ins = 16'($urandom);
            ins[15:12] = 4'($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(9, 14));
         end
         2, 3: begin
            grp = 3'($urandom);
            ins = {4'h7, grp, 9'($urandom)};
            if ((grp == 3'd2 || grp == 3'd3) && $urandom_range(0, 4) != 0)
               b = 16'($signed($urandom_range(0, 63)) - 32);
            if (grp == 3'd1 && $urandom_range(0, 2) != 0)
               a = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(0, 7));
         end
         4: ins = {10'b0000000011, 6'($urandom)};
         5, 6: begin
            ins = {1'($urandom), 4'b0000, 3'($urandom), 8'($urandom)};
            if (ins[15] == 0 && ins[10:8] == 0) ins[8] = 1;
         end
         7, 8: ins = {1'($urandom), 3'b000, 6'($urandom_range(6'h28, 6'h37)), 6'($urandom)};
         default: ins = 16'($urandom);
      endcase
      issue_instruction(ins, a, b, ap, 16'($urandom));
   endtask

   // Response side: per transaction a random hold-off before tready rises.
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int wait_cycles;
      reset = 1;
      cycles = 0;
      no_idle = 0;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      issue_instruction(16'h1000, 16'h8000, 16'h1234, 16'h0, 16'h0100);  // mov
      issue_instruction(16'h9000, 16'h00ff, 16'habcd, 16'h0, 16'h0102);  // movb
      issue_instruction(16'h2000, 16'h8000, 16'h0001, 16'h0, 16'h0104);  // cmp
      issue_instruction(16'hA000, 16'h0080, 16'h00ff, 16'h0, 16'h0106);  // cmpb
      issue_instruction(16'h3000, 16'hffff, 16'h0000, 16'h0, 16'h0108);  // bit
      issue_instruction(16'h4000, 16'h00f0, 16'hffff, 16'h0, 16'h010a);  // bic
      issue_instruction(16'h5000, 16'h8000, 16'h0001, 16'h0, 16'h010c);  // bis
      issue_instruction(16'h6000, 16'h7fff, 16'h0001, 16'h0, 16'h010e);  // add overflow
      issue_instruction(16'hE000, 16'h0001, 16'h8000, 16'h0, 16'h0110);  // sub
      issue_instruction(16'h7000, 16'h8000, 16'h8000, 16'h0, 16'h0112);  // mul even
      issue_instruction(16'h7040, 16'hffff, 16'h7fff, 16'h0, 16'h0114);  // mul odd
      issue_instruction(16'h7200, 16'h1234, 16'h0000, 16'h5678, 16'h0116); // divide by zero
      issue_instruction(16'h7200, 16'h7fff, 16'h0001, 16'hffff, 16'h0118); // quotient overflow
      issue_instruction(16'h7200, 16'hffff, 16'h0007, 16'hfff0, 16'h011a); // signed divide
      issue_instruction(16'h7400, 16'h8001, 16'h0000, 16'h0, 16'h011c);  // zero count
      issue_instruction(16'h7400, 16'h0001, 16'h001f, 16'h0, 16'h011e);  // ash 31
      issue_instruction(16'h7400, 16'h8000, 16'hffe0, 16'h0, 16'h0120);  // ash -32
      issue_instruction(16'h7600, 16'h8000, 16'h0020, 16'h1, 16'h0122);  // count out of range
      issue_instruction(16'h7600, 16'h8000, 16'hffff, 16'h1, 16'h0124);  // ashc right
      issue_instruction(16'h7800, 16'hffff, 16'h0f0f, 16'h0, 16'h0126);  // xor
      issue_instruction(16'h7E05, 16'h0001, 16'h0000, 16'h0, 16'h0128);  // sob falls through
      issue_instruction(16'h7E3f, 16'h0005, 16'h0000, 16'h0, 16'h0010);  // sob loops
      issue_instruction(16'h00c0, 16'h80ff, 16'h0000, 16'h0, 16'h012a);  // swab
      issue_instruction(16'h01ff, 16'h0, 16'h0, 16'h0, 16'h0000);        // br backward
      issue_instruction(16'h0DC0, 16'h0, 16'h0, 16'h0, 16'h012c);        // sxt
      issue_instruction(16'h0D00, 16'h0, 16'h0, 16'h0, 16'h012e);        // unimplemented code: no match
      issue_instruction(16'h7A00, 16'h0, 16'h0, 16'h0, 16'h0130);        // unused group slot

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = (i >= 200 && i < 260);
         if (i == 300) begin
            // Hold the sender until the block has drained completely.
            req_tvalid <= 0;
            while (pending_count != 0) @(negedge clock);
         end
         issue_random();
      end
      req_tvalid <= 0;

      while (pending_count != 0) @(negedge clock);
      wait_cycles = 0;
      while (wait_cycles < 60) begin
         @(negedge clock);
         wait_cycles++;
      end
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ minicomputer_alu_branch_unit.f @@
design/mabu_pkg.sv
design/mabu_front.sv
design/mabu_queue.sv
design/mabu_back.sv
design/minicomputer_alu_branch_unit.sv
dv/mabu_checker.sv
dv/tb_minicomputer_alu_branch_unit.sv
